@@ hw/rtl/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_LOCATE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_POS = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_RUN,
      S_PLACE,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic setup;
      logic step;
      logic place;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_zero;
      logic matched;
      logic place_needed;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ hw/rtl/sle_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath
// Element store, length register, walk pointer and response register.
// ----------------------------------------------------------------------------
module sle_datapath #(
   parameter int CAPACITY = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_position,
   input  logic signed [31:0]    req_value,
   input  sle_pkg::cmd_type      cmd,
   output sle_pkg::dp_status_type st,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_found_position,
   output logic signed [31:0]    rsp_removed_value,
   output logic [7:0]            rsp_list_length
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > 8) ? LW : 8) + 1;

   logic [1:0]          mode_ff, mode_in;
   logic [7:0]          pos_ff, pos_in;
   logic [31:0]         val_ff, val_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [LW-1:0]       cnt_ff, cnt_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic                first_ff, first_in;
   logic                matched_ff, matched_in;
   logic                place_ff, place_in;
   logic [1:0]          status_ff, status_in;
   logic [7:0]          found_ff, found_in;
   logic [31:0]         removed_ff, removed_in;
   logic [31:0]         rdata_ff;
   logic [31:0]         store_ff [CAPACITY];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_found_ff, rsp_found_in;
   logic [31:0]         rsp_removed_ff, rsp_removed_in;
   logic [7:0]          rsp_length_ff, rsp_length_in;

   logic [CW-1:0]       pos_w, len_w;
   logic                ins_bad, del_bad, full;
   logic [LW-1:0]       walk_cnt;
   logic [LW-1:0]       len_next;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [31:0]         wr_data;

   assign pos_w    = CW'(pos_ff);
   assign len_w    = CW'(len_ff);
   assign ins_bad  = (pos_w == '0) || (pos_w > len_w + CW'(1));
   assign del_bad  = (pos_w == '0) || (pos_w > len_w);
   assign full     = (len_w >= CW'(CAPACITY));
   assign walk_cnt = LW'(len_w - pos_w + CW'(1));

   always_comb begin
      len_next = len_ff;
      if (status_ff == sle_pkg::ST_OK) begin
         if (mode_ff == sle_pkg::MODE_INSERT) begin
            len_next = len_ff + LW'(1);
         end else if (mode_ff == sle_pkg::MODE_DELETE) begin
            len_next = len_ff - LW'(1);
         end
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      len_in         = len_ff;
      addr_in        = addr_ff;
      cnt_in         = cnt_ff;
      rd_valid_in    = cmd.step;
      rd_addr_in     = rd_addr_ff;
      first_in       = first_ff;
      matched_in     = matched_ff;
      place_in       = place_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_length_in  = rsp_length_ff;
      wr_en          = 1'b0;
      wr_addr        = rd_addr_ff;
      wr_data        = rdata_ff;

      if (cmd.accept) begin
         mode_in = req_mode;
         pos_in  = req_position;
         val_in  = req_value;
      end

      if (cmd.setup) begin
         status_in  = sle_pkg::ST_OK;
         found_in   = '0;
         removed_in = '0;
         matched_in = 1'b0;
         first_in   = 1'b1;
         place_in   = 1'b0;
         cnt_in     = '0;
         addr_in    = '0;
         unique case (mode_ff)
            sle_pkg::MODE_INSERT: begin
               if (ins_bad) begin
                  status_in = sle_pkg::ST_BAD_POS;
               end else if (full) begin
                  status_in = sle_pkg::ST_FULL;
               end else begin
                  // Walk downwards from the last entry so nothing is overwritten.
                  place_in = 1'b1;
                  cnt_in   = walk_cnt;
                  addr_in  = AW'(len_w - CW'(1));
               end
            end
            sle_pkg::MODE_DELETE: begin
               if (del_bad) begin
                  status_in = sle_pkg::ST_BAD_POS;
               end else begin
                  // The first read fetches the removed entry itself.
                  cnt_in  = walk_cnt;
                  addr_in = AW'(pos_w - CW'(1));
               end
            end
            sle_pkg::MODE_LOCATE: begin
               cnt_in = len_ff;
            end
            default: begin
            end
         endcase
      end

      if (cmd.step) begin
         rd_addr_in = addr_ff;
         cnt_in     = cnt_ff - LW'(1);
         if (mode_ff == sle_pkg::MODE_INSERT) begin
            addr_in = addr_ff - AW'(1);
         end else begin
            addr_in = addr_ff + AW'(1);
         end
      end

      // Data read in the previous cycle is consumed here.
      if (rd_valid_ff) begin
         unique case (mode_ff)
            sle_pkg::MODE_INSERT: begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff + AW'(1);
            end
            sle_pkg::MODE_DELETE: begin
               if (first_ff) begin
                  removed_in = rdata_ff;
                  first_in   = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = rd_addr_ff - AW'(1);
               end
            end
            sle_pkg::MODE_LOCATE: begin
               if (!matched_ff && (rdata_ff == val_ff)) begin
                  matched_in = 1'b1;
                  found_in   = 8'(CW'(rd_addr_ff) + CW'(1));
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.place) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pos_w - CW'(1));
         wr_data = val_ff;
      end

      if (cmd.finish) begin
         len_in         = len_next;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_found_in   = found_ff;
         rsp_removed_in = removed_ff;
         rsp_length_in  = 8'(len_next);
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      addr_ff        <= addr_in;
      cnt_ff         <= cnt_in;
      rd_addr_ff     <= rd_addr_in;
      first_ff       <= first_in;
      matched_ff     <= matched_in;
      place_ff       <= place_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_length_ff  <= rsp_length_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rdata_ff <= store_ff[addr_ff];
      end
   end

   assign st.cnt_zero     = (cnt_ff == '0);
   assign st.matched      = matched_ff;
   assign st.place_needed = place_ff;
   assign st.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_list_length    = rsp_length_ff;

endmodule

@@ hw/rtl/sle_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_controller
// Sequences one transaction: capture, range check, store walk, place write, response.
// ----------------------------------------------------------------------------
module sle_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sle_pkg::dp_status_type st,
   output sle_pkg::cmd_type       cmd
);

   sle_pkg::state_type state_ff, state_in;
   logic               walk_end;

   // A locate may stop early once the first match has been seen.
   assign walk_end = st.cnt_zero || st.matched;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sle_pkg::S_SETUP;
            end
         end
         sle_pkg::S_SETUP: begin
            state_in = sle_pkg::S_RUN;
         end
         sle_pkg::S_RUN: begin
            if (walk_end) begin
               state_in = st.place_needed ? sle_pkg::S_PLACE : sle_pkg::S_DONE;
            end
         end
         sle_pkg::S_PLACE: begin
            state_in = sle_pkg::S_DONE;
         end
         sle_pkg::S_DONE: begin
            if (st.rsp_free) begin
               state_in = sle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         sle_pkg::S_SETUP: begin
            cmd.setup = 1'b1;
         end
         sle_pkg::S_RUN: begin
            cmd.step = !walk_end;
         end
         sle_pkg::S_PLACE: begin
            cmd.place = 1'b1;
         end
         sle_pkg::S_DONE: begin
            cmd.finish = st.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hw/rtl/sequential_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit elements with insert, delete and locate.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_valid / req_ready | mode, position, value
//   rsp     | out       | rsp_valid / rsp_ready | status, found_position,
//           |           |                       | removed_value, list_length
//
// Setup checks the range, the walk makes n store reads, a successful insert then writes
// its value, and the response is loaded, after which the next can be accepted. n counts
// the store reads, one per cycle: length - position + 1 for insert and delete, up to one
// past the first match (at most length) for locate, zero for a rejected or ignored item.
// Reset clears the length and the controller; the store is not cleared. A waiting response
// holds only the completion of the next transaction, never its acceptance.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
   parameter int CAPACITY = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_found_position,
   output logic signed [31:0] rsp_removed_value,
   output logic [7:0]         rsp_list_length
);

   sle_pkg::cmd_type       cmd;
   sle_pkg::dp_status_type st;

   sle_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   sle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .cmd                (cmd),
      .st                 (st),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_list_length    (rsp_list_length)
   );

endmodule

@@ tb/tb_sequential_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine
// Self-checking bench for the sequential list engine. A queue-fed driver
// offers insert, delete, locate and unused-code transactions, and a monitor predicts each
// response from a shadow copy of the list and compares it field by field.
// The run steps through several idling phases and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;

   localparam int CAPACITY       = 128;
   localparam int HOLD_AT        = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 2 * CAPACITY;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 257;

   // The block answers this code with an OK status and leaves the list unchanged.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         position;
      logic signed [31:0] value;
   } list_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         found_position;
      logic signed [31:0] removed_value;
      logic [7:0]         list_length;
   } list_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = sle_pkg::MODE_INSERT;
   logic [7:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_found_position;
   logic signed [31:0] rsp_removed_value;
   logic [7:0]         rsp_list_length;

   list_req_type pending_req_q[$];
   list_rsp_type expected_rsp_q[$];

   // Shadow of the list, owned by the monitor.
   logic signed [31:0] list_store [CAPACITY];
   int                 list_len;

   // Length as the stimulus planner sees it, so that it can aim positions.
   int plan_len = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int accepted_reqs = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int quiet_cycles  = 0;
   int error_count   = 0;

   int n_insert_ok = 0, n_delete_ok = 0, n_locate_hit = 0, n_locate_miss = 0;
   int n_bad_pos = 0, n_full = 0, n_unused = 0, peak_len = 0;

   sequential_list_engine #(.CAPACITY(CAPACITY)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_list_length    (rsp_list_length)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string field, input longint got, input longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
      end
   endtask

   // Applies one transaction to the shadow list and returns its response.
   function automatic list_rsp_type apply_list_op(input list_req_type op);
      list_rsp_type r;
      int           pos;
      int           k;
      r   = '0;
      pos = op.position;
      r.status = sle_pkg::ST_OK;
      case (op.mode)
         sle_pkg::MODE_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               r.status = sle_pkg::ST_BAD_POS;
               n_bad_pos++;
            end else if (list_len >= CAPACITY) begin
               r.status = sle_pkg::ST_FULL;
               n_full++;
            end else begin
               for (k = list_len; k >= pos; k--) list_store[k] = list_store[k - 1];
               list_store[pos - 1] = op.value;
               list_len++;
               n_insert_ok++;
            end
         end
         sle_pkg::MODE_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               r.status = sle_pkg::ST_BAD_POS;
               n_bad_pos++;
            end else begin
               r.removed_value = list_store[pos - 1];
               for (k = pos; k < list_len; k++) list_store[k - 1] = list_store[k];
               list_len--;
               n_delete_ok++;
            end
         end
         sle_pkg::MODE_LOCATE: begin
            for (k = 0; k < list_len && r.found_position == 0; k++) begin
               if (list_store[k] == op.value) r.found_position = 8'(k + 1);
            end
            if (r.found_position != 0) n_locate_hit++;
            else n_locate_miss++;
         end
         default: n_unused++;
      endcase
      r.list_length = 8'(list_len);
      if (list_len > peak_len) peak_len = list_len;
      return r;
   endfunction

   task automatic queue_item(input logic [1:0] mode, input int pos,
                             input logic signed [31:0] val);
      list_req_type it;
      it.mode     = mode;
      it.position = 8'(pos);
      it.value    = val;
      pending_req_q.push_back(it);
      if (mode == sle_pkg::MODE_INSERT && pos >= 1 && pos <= plan_len + 1
          && plan_len < CAPACITY) begin
         plan_len++;
      end else if (mode == sle_pkg::MODE_DELETE && pos >= 1 && pos <= plan_len) begin
         plan_len--;
      end
   endtask

   // Half the values come from a small set so that duplicates and locate hits are common.
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(1)) return $urandom;
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         4: return 32'sd100;
         default: return 32'sd7;
      endcase
   endfunction

   task automatic queue_random(input int count, input int insert_pct, input int delete_pct);
      int  n;
      int  roll;
      int  pos;
      bit  good;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         good = $urandom_range(99) < 85;
         if (roll < insert_pct) begin
            if (good) pos = $urandom_range(plan_len + 1, 1);
            else if ($urandom_range(1)) pos = 0;
            else pos = $urandom_range(255, plan_len + 2);
            queue_item(sle_pkg::MODE_INSERT, pos, pick_value());
         end else if (roll < insert_pct + delete_pct) begin
            if (good && plan_len > 0) pos = $urandom_range(plan_len, 1);
            else if ($urandom_range(1)) pos = 0;
            else pos = $urandom_range(255, plan_len + 1);
            queue_item(sle_pkg::MODE_DELETE, pos, $urandom);
         end else if (roll < 98) begin
            queue_item(sle_pkg::MODE_LOCATE, $urandom_range(255), pick_value());
         end else begin
            queue_item(MODE_UNUSED, $urandom_range(255), $urandom);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Driver: a new transaction is presented only once the previous one has gone.
   always @(posedge clock) begin
      list_req_type next_req;
      if (reset) begin
         req_valid    <= 1'b0;
         req_mode     <= sle_pkg::MODE_INSERT;
         req_position <= '0;
         req_value    <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_req_q.pop_front();
            req_valid    <= 1'b1;
            req_mode     <= next_req.mode;
            req_position <= next_req.position;
            req_value    <= next_req.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that lets the block back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         list_len = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_found_position, rsp_removed_value, rsp_list_length};
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding: status %0d length %0d",
                                         got.status, got.list_length));
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("status", got.status, want.status);
               compare_field("found_position", got.found_position, want.found_position);
               compare_field("removed_value", got.removed_value, want.removed_value);
               compare_field("list_length", got.list_length, want.list_length);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_list_op('{req_mode, req_position, req_value}));
            accepted_reqs <= accepted_reqs + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
         $display("sequential_list_engine verification failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, bad positions on both sides, extremes, duplicates.
      queue_item(sle_pkg::MODE_LOCATE, 0, 32'sd0);
      queue_item(sle_pkg::MODE_DELETE, 1, 32'sd0);
      queue_item(sle_pkg::MODE_INSERT, 0, 32'sd5);
      queue_item(sle_pkg::MODE_INSERT, 2, 32'sd5);
      queue_item(sle_pkg::MODE_INSERT, 255, 32'sd5);
      queue_item(sle_pkg::MODE_INSERT, 1, 32'sh8000_0000);
      queue_item(sle_pkg::MODE_INSERT, 2, 32'sh7FFF_FFFF);
      queue_item(sle_pkg::MODE_INSERT, 1, -32'sd1);
      queue_item(sle_pkg::MODE_INSERT, 2, 32'sd0);
      queue_item(sle_pkg::MODE_INSERT, 5, 32'sh8000_0000);
      queue_item(sle_pkg::MODE_LOCATE, 0, 32'sh8000_0000);
      queue_item(sle_pkg::MODE_LOCATE, 0, 32'sh7FFF_FFFF);
      queue_item(sle_pkg::MODE_LOCATE, 255, -32'sd1);
      queue_item(sle_pkg::MODE_LOCATE, 0, 32'sd12345);
      queue_item(MODE_UNUSED, 255, -32'sd1);
      queue_item(sle_pkg::MODE_DELETE, 0, 32'sd0);
      queue_item(sle_pkg::MODE_DELETE, 6, 32'sd0);
      queue_item(sle_pkg::MODE_DELETE, 255, 32'sd0);
      queue_item(sle_pkg::MODE_DELETE, 5, 32'sd0);
      queue_item(sle_pkg::MODE_DELETE, 1, 32'sd0);
      queue_item(sle_pkg::MODE_INSERT, 4, 32'sd100);
      queue_item(sle_pkg::MODE_DELETE, 2, 32'sd0);
      wait_drained();

      // Alternate filling and draining phases so that both full and empty lists recur.
      queue_random(PHASE_ITEMS, 75, 15);
      wait_drained();

      send_idle_pct = 73;
      queue_random(PHASE_ITEMS, 15, 75);
      wait_drained();

      send_idle_pct = 0;
      rsp_stall_pct = 73;
      queue_random(PHASE_ITEMS, 75, 15);
      wait_drained();

      send_idle_pct = 27;
      rsp_stall_pct = 27;
      queue_random(PHASE_ITEMS, 15, 75);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));
      end

      $display("Covered %0d transactions: %0d inserts, %0d deletes, %0d locate hits, %0d misses.",
               accepted_reqs, n_insert_ok, n_delete_ok, n_locate_hit, n_locate_miss);
      $display("Rejected %0d bad positions and %0d full inserts; %0d unused; peak length %0d.",
               n_bad_pos, n_full, n_unused, peak_len);
      if (error_count == 0) begin
         $display("sequential_list_engine verification clean");
      end else begin
         $display("sequential_list_engine verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sle_pkg.sv
hw/rtl/sle_datapath.sv
hw/rtl/sle_controller.sv
hw/rtl/sequential_list_engine.sv
tb/tb_sequential_list_engine.sv
